>>> rtl/cosine_gradient_palette_core_assert.svh
// ----------------------------------------------------------------------------
// Cosine gradient palette: assertion macros
// Concurrent checks used by the controller module.
// ----------------------------------------------------------------------------
`ifndef COSINE_GRADIENT_PALETTE_CORE_ASSERT_SVH
`define COSINE_GRADIENT_PALETTE_CORE_ASSERT_SVH

// same-cycle implication
`define CGP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CGP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cgp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette package
// Shared constants, datapath operation codes and control/status structs.
// ----------------------------------------------------------------------------
package cgp_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int NUM_CH       = 3;
    localparam int DIV_W        = 34;
    localparam int HORNER_STEPS = 6;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [16:0] FRAC_ONE = 17'h10000;
    localparam logic [16:0] FRAC_HALF = 17'h08000;
    localparam logic [15:0] LEN_RESET = 16'd256;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_APPEND,
        OP_X_START,
        OP_X_LATCH,
        OP_CH_ZERO,
        OP_SCAN_INIT,
        OP_SCAN_NEXT,
        OP_PICK_B,
        OP_LATCH_B,
        OP_LATCH_A,
        OP_T_DIRECT,
        OP_T_START,
        OP_T_LATCH,
        OP_COS_MUL,
        OP_SQUARE,
        OP_U_LATCH,
        OP_H_MUL,
        OP_H_DIV,
        OP_H_STEP,
        OP_BLEND_MUL,
        OP_NUM,
        OP_ROUND,
        OP_PUBLISH
    } cgp_op_t;

    typedef struct packed {
        cgp_op_t op;
    } cgp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic hit;
        logic last;
        logic cnt_zero;
        logic ch_done;
        logic span_zero;
        logic step_last;
    } cgp_status_t;

    // Horner divisors 132, 90, 56, 30, 12, 2 split as 2^k * m, m odd;
    // floor(v / m) = (v * ceil(2^s / m)) >> s, exact for v < 2^(32-k)
    function automatic logic [31:0] horner_pre(input logic [2:0] k, input logic [31:0] v);
        logic [31:0] r;
        unique case (k)
            3'd0:    r = v >> 2;
            3'd1:    r = v >> 1;
            3'd2:    r = v >> 3;
            3'd3:    r = v >> 1;
            3'd4:    r = v >> 2;
            default: r = v >> 1;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] horner_magic(input logic [2:0] k);
        logic [31:0] m;
        unique case (k)
            3'd0:    m = 32'(((64'd1 << 36) + 64'd32) / 64'd33);
            3'd1:    m = 32'(((64'd1 << 37) + 64'd44) / 64'd45);
            3'd2:    m = 32'(((64'd1 << 32) + 64'd6) / 64'd7);
            3'd3:    m = 32'(((64'd1 << 35) + 64'd14) / 64'd15);
            3'd4:    m = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
            default: m = 32'd1;
        endcase
        return m;
    endfunction

    function automatic logic [33:0] horner_post(input logic [2:0] k, input logic [63:0] p);
        logic [33:0] q;
        unique case (k)
            3'd0:    q = 34'(p >> 36);
            3'd1:    q = 34'(p >> 37);
            3'd2:    q = 34'(p >> 32);
            3'd3:    q = 34'(p >> 35);
            3'd4:    q = 34'(p >> 32);
            default: q = p[33:0];
        endcase
        return q;
    endfunction

endpackage

>>> rtl/cgp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette: iterative divider
// Restoring division, one quotient bit per cycle, 34-bit dividend.
// ----------------------------------------------------------------------------
module cgp_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cgp_pkg::DIV_W-1:0]  dividend,
    input  logic [15:0]                divisor,
    output logic                       busy,
    output logic                       done,
    output logic [cgp_pkg::DIV_W-1:0]  quotient
);
    import cgp_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      rem_reg;
    logic [15:0]      dsr_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [16:0]      trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 16'(trial - {1'b0, dsr_reg}) : trial[15:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/cgp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette: datapath
// Point memory, counts, shared multiplier and divider, blend and rounding.
// ----------------------------------------------------------------------------
module cgp_datapath #(
    parameter int MAX_POINTS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cgp_pkg::cgp_cmd_t    cmd,
    output cgp_pkg::cgp_status_t status,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    input  logic [1:0]           channel_select,
    input  logic [15:0]          point_position,
    input  logic [16:0]          point_level,
    input  logic [15:0]          palette_index,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);
    import cgp_pkg::*;

    localparam int DEPTH = NUM_CH * MAX_POINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam logic [55:0] ROUND_HALF = 56'd1 << 45;

    logic [32:0]      mem [DEPTH];
    logic [32:0]      rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic [CW-1:0]    cnt_reg [NUM_CH];
    logic [15:0]      len_reg;
    logic [15:0]      len_eff;

    logic [1:0]       ch_reg;
    logic [15:0]      x_reg;
    logic [KW-1:0]    k_reg;
    logic [KW-1:0]    a_reg;
    logic [15:0]      pos_a_reg, pos_b_reg;
    logic [16:0]      lvl_a_reg, lvl_b_reg;
    logic [16:0]      t_reg;
    logic             upper_reg;
    logic [31:0]      u_reg;
    logic [30:0]      r_reg;
    logic [2:0]       step_reg;
    logic [63:0]      prod_reg;
    logic [47:0]      num_reg;
    logic [7:0]       color_reg [NUM_CH];
    logic [7:0]       red_reg, green_reg, blue_reg;

    logic [1:0]       cnt_idx;
    logic [CW-1:0]    n_cur;
    logic             app_ok;
    logic [16:0]      lvl_clamp;
    logic [15:0]      rd_pos;
    logic [KW-1:0]    b_sel;
    logic [KW-1:0]    a_sel;
    logic [15:0]      d_val, span_val;
    logic             t_upper;
    logic [16:0]      tt;
    logic [31:0]      half_w;
    logic [30:0]      w_val;
    logic             lvl_ge;
    logic [16:0]      lvl_diff;
    logic [31:0]      mul_a, mul_b;
    logic [55:0]      scaled;
    logic [33:0]      t_q;
    logic [33:0]      p_q;
    logic [AW-1:0]    base;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [15:0]      div_divisor;
    logic             div_busy, div_done;
    logic [DIV_W-1:0] div_q;

    cgp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign len_eff   = (len_reg == 16'd0) ? 16'd1 : len_reg;
    assign cnt_idx   = (cmd.op == OP_APPEND) ? channel_select : ch_reg;
    assign n_cur     = (cnt_idx < 2'(NUM_CH)) ? cnt_reg[cnt_idx] : '0;
    assign app_ok    = (channel_select < 2'(NUM_CH)) && (n_cur < CW'(MAX_POINTS));
    assign lvl_clamp = (point_level > FRAC_ONE) ? FRAC_ONE : point_level;
    assign rd_pos    = rd_data_reg[15:0];
    assign base      = AW'(ch_reg * MAX_POINTS);
    assign b_sel     = (rd_pos >= x_reg) ? k_reg : '0;
    assign a_sel     = (b_sel == '0) ? KW'(n_cur - CW'(1)) : KW'(b_sel - KW'(1));
    assign d_val     = x_reg - pos_a_reg;
    assign span_val  = pos_b_reg - pos_a_reg;
    assign t_upper   = t_reg > FRAC_HALF;
    assign tt        = t_upper ? 17'(FRAC_ONE - t_reg) : t_reg;
    assign half_w    = ({1'b0, Q30_ONE} + {1'b0, r_reg}) >> 1;
    assign w_val     = upper_reg ? 31'(Q30_ONE - half_w[30:0]) : half_w[30:0];
    assign lvl_ge    = lvl_a_reg >= lvl_b_reg;
    assign lvl_diff  = lvl_ge ? 17'(lvl_a_reg - lvl_b_reg) : 17'(lvl_b_reg - lvl_a_reg);
    assign scaled    = ({num_reg, 8'd0} - {8'd0, num_reg}) + ROUND_HALF;
    assign t_q       = div_q;
    assign p_q       = horner_post(step_reg, prod_reg);

    always_comb
    begin
        unique case (cmd.op)
            OP_APPEND:    rd_addr = AW'(channel_select * MAX_POINTS);
            OP_SCAN_INIT: rd_addr = base;
            OP_SCAN_NEXT: rd_addr = base + AW'(k_reg) + AW'(1);
            OP_PICK_B:    rd_addr = base + AW'(b_sel);
            OP_LATCH_B:   rd_addr = base + AW'(a_reg);
            default:      rd_addr = base;
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 16'd1;
        unique case (cmd.op)
            OP_X_START:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({palette_index, 16'd0});
                div_divisor  = len_eff;
            end
            OP_T_START:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({d_val, 16'd0});
                div_divisor  = span_val;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.op)
            OP_COS_MUL:
            begin
                mul_a = 32'(tt);
                mul_b = PI_Q30;
            end
            OP_SQUARE:
            begin
                mul_a = prod_reg[47:16];
                mul_b = prod_reg[47:16];
            end
            OP_H_MUL:
            begin
                mul_a = u_reg;
                mul_b = {1'b0, r_reg};
            end
            OP_H_DIV:
            begin
                mul_a = horner_pre(step_reg, prod_reg[61:30]);
                mul_b = horner_magic(step_reg);
            end
            default:
            begin
                mul_a = {1'b0, w_val};
                mul_b = 32'(lvl_diff);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            for (int i = 0; i < NUM_CH; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (cmd.op == OP_APPEND && app_ok)
            begin
                cnt_reg[channel_select] <= n_cur + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_APPEND && app_ok)
        begin
            mem[AW'(channel_select * MAX_POINTS) + AW'(n_cur)] <= {lvl_clamp, point_position};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_X_LATCH:
            begin
                x_reg  <= div_q[15:0];
                ch_reg <= '0;
            end
            OP_CH_ZERO:
            begin
                color_reg[ch_reg] <= 8'd0;
                ch_reg            <= ch_reg + 2'd1;
            end
            OP_SCAN_INIT: k_reg <= '0;
            OP_SCAN_NEXT: k_reg <= k_reg + KW'(1);
            OP_PICK_B:    a_reg <= a_sel;
            OP_LATCH_B:
            begin
                pos_b_reg <= rd_data_reg[15:0];
                lvl_b_reg <= rd_data_reg[32:16];
            end
            OP_LATCH_A:
            begin
                pos_a_reg <= rd_data_reg[15:0];
                lvl_a_reg <= rd_data_reg[32:16];
            end
            OP_T_DIRECT:  t_reg <= {1'b0, d_val};
            OP_T_LATCH:   t_reg <= (t_q > 34'(FRAC_ONE)) ? FRAC_ONE : t_q[16:0];
            OP_COS_MUL:
            begin
                upper_reg <= t_upper;
                prod_reg  <= mul_a * mul_b;
            end
            OP_SQUARE:    prod_reg <= mul_a * mul_b;
            OP_U_LATCH:
            begin
                u_reg    <= prod_reg[61:30];
                r_reg    <= Q30_ONE;
                step_reg <= '0;
            end
            OP_H_MUL:     prod_reg <= mul_a * mul_b;
            OP_H_DIV:     prod_reg <= mul_a * mul_b;
            OP_H_STEP:
            begin
                r_reg    <= (p_q >= 34'(Q30_ONE)) ? 31'd0 : 31'(34'(Q30_ONE) - p_q);
                step_reg <= step_reg + 3'd1;
            end
            OP_BLEND_MUL: prod_reg <= mul_a * mul_b;
            OP_NUM:
            begin
                num_reg <= lvl_ge ? 48'({lvl_b_reg, 30'd0}) + prod_reg[47:0]
                                  : 48'({lvl_b_reg, 30'd0}) - prod_reg[47:0];
            end
            OP_ROUND:
            begin
                color_reg[ch_reg] <= scaled[53:46];
                ch_reg            <= ch_reg + 2'd1;
            end
            OP_PUBLISH:
            begin
                red_reg   <= color_reg[0];
                green_reg <= color_reg[1];
                blue_reg  <= color_reg[2];
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    always_comb
    begin
        status.div_busy  = div_busy;
        status.div_done  = div_done;
        status.hit       = rd_pos >= x_reg;
        status.last      = (CW'(k_reg) + CW'(1)) == n_cur;
        status.cnt_zero  = n_cur == '0;
        status.ch_done   = ch_reg == 2'(NUM_CH);
        status.span_zero = span_val == 16'd0;
        status.step_last = step_reg == 3'(HORNER_STEPS - 1);
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

>>> rtl/cgp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette: controller
// Sequences appends and lookups, owns the handshakes on both channels.
// ----------------------------------------------------------------------------
`include "cosine_gradient_palette_core_assert.svh"

module cgp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cgp_pkg::cgp_cmd_t    cmd,
    input  cgp_pkg::cgp_status_t status
);
    import cgp_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIVX,
        ST_CH,
        ST_SCAN,
        ST_RDB,
        ST_RDA,
        ST_TDIV,
        ST_WAIT_T,
        ST_COS,
        ST_SQ,
        ST_ULAT,
        ST_HMUL,
        ST_HDIV,
        ST_HWAIT,
        ST_BLEND,
        ST_NUM,
        ST_RND,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind)
                    begin
                        cmd.op     = OP_X_START;
                        state_next = ST_DIVX;
                    end
                    else
                    begin
                        cmd.op = OP_APPEND;
                    end
                end
            end
            ST_DIVX:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_X_LATCH;
                    state_next = ST_CH;
                end
            end
            ST_CH:
            begin
                priority if (status.ch_done)
                begin
                    state_next = ST_FIN;
                end
                else if (status.cnt_zero)
                begin
                    cmd.op = OP_CH_ZERO;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.hit || status.last)
                begin
                    cmd.op     = OP_PICK_B;
                    state_next = ST_RDB;
                end
                else
                begin
                    cmd.op = OP_SCAN_NEXT;
                end
            end
            ST_RDB:
            begin
                cmd.op     = OP_LATCH_B;
                state_next = ST_RDA;
            end
            ST_RDA:
            begin
                cmd.op     = OP_LATCH_A;
                state_next = ST_TDIV;
            end
            ST_TDIV:
            begin
                if (status.span_zero)
                begin
                    cmd.op     = OP_T_DIRECT;
                    state_next = ST_COS;
                end
                else
                begin
                    cmd.op     = OP_T_START;
                    state_next = ST_WAIT_T;
                end
            end
            ST_WAIT_T:
            begin
                if (status.div_done)
                begin
                    cmd.op     = OP_T_LATCH;
                    state_next = ST_COS;
                end
            end
            ST_COS:
            begin
                cmd.op     = OP_COS_MUL;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.op     = OP_SQUARE;
                state_next = ST_ULAT;
            end
            ST_ULAT:
            begin
                cmd.op     = OP_U_LATCH;
                state_next = ST_HMUL;
            end
            ST_HMUL:
            begin
                cmd.op     = OP_H_MUL;
                state_next = ST_HDIV;
            end
            ST_HDIV:
            begin
                cmd.op     = OP_H_DIV;
                state_next = ST_HWAIT;
            end
            ST_HWAIT:
            begin
                cmd.op     = OP_H_STEP;
                state_next = status.step_last ? ST_BLEND : ST_HMUL;
            end
            ST_BLEND:
            begin
                cmd.op     = OP_BLEND_MUL;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.op     = OP_NUM;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                cmd.op     = OP_ROUND;
                state_next = ST_CH;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;

    `CGP_ASSERT_IMP(a_publish_free, clk, rst_n, cmd.op == OP_PUBLISH, !out_valid_reg || !out_stall, "result overwrites pending transfer")
    `CGP_ASSERT_IMP(a_div_start_idle, clk, rst_n, cmd.op == OP_X_START || cmd.op == OP_T_START, !status.div_busy, "divider started while busy")
    `CGP_ASSERT_IMP(a_div_done_wait, clk, rst_n, status.div_done, state_reg == ST_DIVX || state_reg == ST_WAIT_T, "divider finished outside a wait state")

endmodule

>>> rtl/cosine_gradient_palette_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette core
// Cyclic color gradient with half-cosine blending between control points.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  cfg      | cfg_we               | cfg_wdata (palette_length)
//  in       | in_valid / in_stall  | kind, channel_select, point_position,
//           |                      | point_level, palette_index
//  out      | out_valid / out_stall| red, green, blue
//
//  Lookup: the bit-serial divider divides the index by palette_length, then each
//  channel scans its points, divides for t (skipped when the span is zero),
//  runs the cosine steps, blends and rounds; an empty channel reads zero, and
//  the color is then published. One item at a time; the result waits in an
//  output register while the next item is taken. Reset clears the point
//  counts, palette_length reads 256.
// ----------------------------------------------------------------------------
module cosine_gradient_palette_core #(
    parameter int MAX_POINTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [1:0]  channel_select,
    input  logic [15:0] point_position,
    input  logic [16:0] point_level,
    input  logic [15:0] palette_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);
    import cgp_pkg::*;

    cgp_cmd_t    cmd;
    cgp_status_t status;

    cgp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cgp_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .channel_select (channel_select),
        .point_position (point_position),
        .point_level    (point_level),
        .palette_index  (palette_index),
        .red            (red),
        .green          (green),
        .blue           (blue)
    );

endmodule

>>> sim/cgp_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette checker
// Watches the input and output channels and the palette_length register,
// computes the expected color of every lookup and compares it with the
// block's result.
// ----------------------------------------------------------------------------
module cgp_scoreboard #(
    parameter int MAX_POINTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [1:0]  channel_select,
    input  logic [15:0] point_position,
    input  logic [16:0] point_level,
    input  logic [15:0] palette_index,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output int          fail_count,
    output int          pending
);
    import cgp_pkg::*;

    localparam int NCH = 3;

    logic [15:0] len_reg;
    logic [15:0] pos_mem [NCH*MAX_POINTS];
    logic [16:0] lvl_mem [NCH*MAX_POINTS];
    int          npts [NCH];
    logic [23:0] color_q [$];

    function automatic logic [63:0] cos_weight(input logic [63:0] t_in);
        logic        upper;
        logic [63:0] t, theta, u, r, p, w;
        upper = (t_in * 2) > 64'(FRAC_ONE);
        t = upper ? 64'(FRAC_ONE) - t_in : t_in;
        theta = (t * 64'(PI_Q30)) >> FRAC_BITS;
        u = (theta * theta) >> 30;
        r = 64'(Q30_ONE);
        for (int k = 0; k < 6; k++)
        begin
            case (k)
                0: p = ((u * r) >> 30) / 132;
                1: p = ((u * r) >> 30) / 90;
                2: p = ((u * r) >> 30) / 56;
                3: p = ((u * r) >> 30) / 30;
                4: p = ((u * r) >> 30) / 12;
                default: p = ((u * r) >> 30) / 2;
            endcase
            r = (p >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - p;
        end
        w = (64'(Q30_ONE) + r) >> 1;
        return upper ? 64'(Q30_ONE) - w : w;
    endfunction

    function automatic logic [7:0] channel_level(input int c, input logic [63:0] x);
        int          n, base, ia, ib;
        logic [63:0] xa, xb, ya, yb, d, span, t, w, num, y;
        n = npts[c];
        base = c * MAX_POINTS;
        ib = 0;
        if (n == 0)
            return 8'd0;
        for (int k = n - 1; k >= 0; k--)
        begin
            if (64'(pos_mem[base+k]) >= x)
                ib = k;
        end
        ia = (ib == 0) ? n - 1 : ib - 1;
        xa = 64'(pos_mem[base+ia]);
        xb = 64'(pos_mem[base+ib]);
        ya = 64'(lvl_mem[base+ia]);
        yb = 64'(lvl_mem[base+ib]);
        d = (x - xa) & 64'hFFFF;
        span = (xb - xa) & 64'hFFFF;
        t = (span != 0) ? (d << FRAC_BITS) / span : d;
        if (t > 64'(FRAC_ONE))
            t = 64'(FRAC_ONE);
        w = cos_weight(t);
        if (ya >= yb)
            num = (yb << 30) + w * (ya - yb);
        else
            num = (yb << 30) - w * (yb - ya);
        y = (num * 255 + (64'd1 << 45)) >> 46;
        return y[7:0];
    endfunction

    function automatic logic [23:0] lookup_color(input logic [15:0] index);
        logic [63:0] len, idx, x;
        len = (len_reg == 0) ? 64'd1 : 64'(len_reg);
        idx = 64'(index) % len;
        x = (idx << FRAC_BITS) / len;
        return {channel_level(0, x), channel_level(1, x), channel_level(2, x)};
    endfunction

    assign pending = color_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] exp_c;
        int          n;
        logic [16:0] lv;
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            for (int c = 0; c < NCH; c++)
                npts[c] = 0;
            color_q.delete();
            fail_count <= 0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (color_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h %h %h", red, green, blue);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_c = color_q.pop_front();
                    if ({red, green, blue} !== exp_c)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     exp_c[23:16], exp_c[15:8], exp_c[7:0], red, green, blue);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (kind)
                    color_q.push_back(lookup_color(palette_index));
                else if (channel_select < NCH)
                begin
                    n = npts[channel_select];
                    if (n < MAX_POINTS)
                    begin
                        lv = (point_level > FRAC_ONE) ? FRAC_ONE : point_level;
                        pos_mem[channel_select*MAX_POINTS+n] = point_position;
                        lvl_mem[channel_select*MAX_POINTS+n] = lv;
                        npts[channel_select] = n + 1;
                    end
                end
            end
        end
    end
endmodule

>>> sim/tb_cosine_gradient_palette_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cosine gradient palette core testbench
// Builds control points per channel, runs directed and random lookups under
// several palette lengths with random idling on both sides, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module tb_cosine_gradient_palette_core;
    import cgp_pkg::*;

    localparam int LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        kind = 1'b0;
    logic [1:0]  channel_select = '0;
    logic [15:0] point_position = '0;
    logic [16:0] point_level = '0;
    logic [15:0] palette_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red, green, blue;
    int          fail_count, pending;
    int          idle_cycles = 0;
    bit          no_idle = 1'b0;
    logic [15:0] cur_len = 16'd256;
    int          sent = 0;

    always #1 clk = ~clk;

    cosine_gradient_palette_core dut (.*);

    cgp_scoreboard chk (.*);

    always @(posedge clk)
    begin
        if (in_valid && !in_stall || out_valid && !out_stall)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 32);

    task automatic send(input logic k, input logic [1:0] ch, input logic [15:0] pos,
                        input logic [16:0] lvl, input logic [15:0] idx);
        while (!no_idle && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        channel_select <= ch;
        point_position <= pos;
        point_level <= lvl;
        palette_index <= idx;
        @(negedge clk);
        while (in_stall)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    task automatic set_length(input logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        cur_len = v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic lookup_rand();
        logic [15:0] idx;
        if ($urandom_range(9) == 0)
            idx = 16'($urandom);
        else
            idx = (cur_len == 0) ? 16'd0 : 16'($urandom_range(cur_len - 1));
        send(1'b1, 2'($urandom), 16'($urandom), 17'($urandom), idx);
    endtask

    task automatic append_rand(input logic [1:0] ch);
        logic [16:0] lvl;
        lvl = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        send(1'b0, ch, 16'($urandom), lvl, 16'($urandom));
    endtask

    initial
    begin
        int          lens [6];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // empty channels, index wraps
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'd0);
        send(1'b1, 2'd3, 16'hFFFF, 17'h1FFFF, 16'hFFFF);
        // ordered red points, clamped level, bad channel
        send(1'b0, 2'd0, 16'd0, 17'd0, 16'd0);
        send(1'b0, 2'd0, 16'h4000, 17'h1FFFF, 16'd0);
        send(1'b0, 2'd0, 16'hFFFF, 17'h10000, 16'd0);
        send(1'b0, 2'd3, 16'h8000, 17'h08000, 16'd0);
        // green: single point, blue: equal positions and unordered
        send(1'b0, 2'd1, 16'h8000, 17'h0C000, 16'd0);
        send(1'b0, 2'd2, 16'h2000, 17'h10000, 16'd0);
        send(1'b0, 2'd2, 16'h2000, 17'h00000, 16'd0);
        send(1'b0, 2'd2, 16'h1000, 17'h04000, 16'd0);
        for (int i = 0; i < 8; i++)
            send(1'b1, 2'd0, 16'd0, 17'd0, 16'(i * 37));
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'd255);
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'd256);
        // fill red past capacity
        for (int i = 0; i < 15; i++)
            send(1'b0, 2'd0, 16'(16'hFF00 + i), 17'($urandom_range(65536)), 16'd0);
        set_length(16'd0);
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'hFFFF);
        set_length(16'hFFFF);
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'hFFFE);
        send(1'b1, 2'd0, 16'd0, 17'd0, 16'hFFFF);
        drain();

        // random phase: reset would clear points, so lengths vary instead;
        // most lookups hit channels already built above
        lens = '{1, 3, 100, 256, 4096, 65535};
        for (int ph = 0; ph < 6; ph++)
        begin
            set_length(16'(lens[ph]));
            no_idle = (ph == 3);
            for (int i = 0; i < 50; i++)
            begin
                if ($urandom_range(4) == 0)
                    append_rand(2'($urandom));
                else
                    lookup_rand();
            end
        end
        no_idle = 1'b0;
        set_length(16'($urandom_range(65535, 1)));
        while (sent < 1750)
            lookup_rand();
        drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
